FILE: src/nfa_em_pkg.sv
// ----------------------------------------------------------------------------
// nfa_em_pkg
// Shared constants and types for the epsilon-NFA matcher: state count,
// field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package nfa_em_pkg;

    // number of automaton states, one bit of each mask per state
    localparam int NUM_STATES = 16;
    localparam int IDX_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    // fixed field widths of the input and result words
    localparam int FIELD_W = 16;
    localparam int OP_W    = 2;
    localparam int ROW_W   = 4;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_ACCEPT_MASK = APB_AW'(0);

    // states at or above NUM_STATES are dropped from each loaded table row
    localparam logic [FIELD_W-1:0] STATE_MASK =
        (NUM_STATES >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << NUM_STATES) - 64'd1);

    // last row visited by one pass of the sequencer
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(NUM_STATES - 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_FEED  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_CLOSE = 4'b0100,
        ST_DONE  = 4'b1000
    } seq_state_t;

endpackage

FILE: src/nfa_epsilon_matcher.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_matcher
// Epsilon-NFA simulator over a two-symbol alphabet. Keeps the active set as a
// bit mask and walks the transition table one row per cycle.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | operation, row_index, next_on_a,
//           |           |                    | next_on_b, next_on_eps, symbol_is_b
//  m_       | out       | m_valid / m_ready  | active_states, accepted
//  apb      | in        | psel / penable     | accept_mask at address 0
//
// a load or an unused operation goes from idle straight to the result stage
// a start runs closure passes only, a feed first runs a symbol scan over every row
// closure passes repeat until one pass adds no state: 1 to NUM_STATES passes
// the single row read port of the transition table makes each pass step through the rows
// reset clears the tables, the active set and accept_mask; a new word is taken
// whenever the sequencer is idle, even while the last result waits on m_ready
// ----------------------------------------------------------------------------
module nfa_epsilon_matcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nfa_em_pkg::OP_W-1:0]    s_operation,
    input  logic [nfa_em_pkg::ROW_W-1:0]   s_row_index,
    input  logic [nfa_em_pkg::FIELD_W-1:0] s_next_on_a,
    input  logic [nfa_em_pkg::FIELD_W-1:0] s_next_on_b,
    input  logic [nfa_em_pkg::FIELD_W-1:0] s_next_on_eps,
    input  logic                          s_symbol_is_b,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [nfa_em_pkg::FIELD_W-1:0] m_active_states,
    output logic                          m_accepted,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nfa_em_pkg::APB_AW-1:0]  paddr,
    input  logic [nfa_em_pkg::APB_DW-1:0]  pwdata,
    output logic [nfa_em_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import nfa_em_pkg::*;

    // transition tables, one row per state
    logic [FIELD_W-1:0] table_a_reg   [NUM_STATES];
    logic [FIELD_W-1:0] table_b_reg   [NUM_STATES];
    logic [FIELD_W-1:0] table_eps_reg [NUM_STATES];

    logic [FIELD_W-1:0] accept_mask_reg;
    logic [FIELD_W-1:0] active_reg,  active_next;
    logic [FIELD_W-1:0] work_reg,    work_next;
    logic [IDX_W-1:0]   row_reg,     row_next;
    logic               changed_reg, changed_next;
    logic               symbol_reg,  symbol_next;
    seq_state_t         state_reg,   state_next;

    logic                 m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]   m_active_reg, m_active_next;
    logic                 m_accepted_reg, m_accepted_next;

    logic                 s_fire;
    logic                 load_fire;
    logic                 row_in_range;
    logic [IDX_W-1:0]     load_row;
    logic [FIELD_W-1:0]   sym_row;
    logic [FIELD_W-1:0]   eps_row;
    logic [FIELD_W-1:0]   closed;
    logic                 out_free;
    logic                 cfg_sel;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // row load decode
    assign row_in_range = ({1'b0, s_row_index} < (ROW_W+1)'(NUM_STATES));
    assign load_row     = s_row_index[IDX_W-1:0];
    assign load_fire    = s_fire && (s_operation == OP_LOAD) && row_in_range;

    // shared table read port, one row per cycle
    assign sym_row = symbol_reg ? table_b_reg[row_reg] : table_a_reg[row_reg];
    assign eps_row = table_eps_reg[row_reg];
    assign closed  = work_reg[row_reg] ? (work_reg | eps_row) : work_reg;

    // table write and reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STATES; i++) begin
                table_a_reg[i]   <= '0;
                table_b_reg[i]   <= '0;
                table_eps_reg[i] <= '0;
            end
        end else if (load_fire) begin
            table_a_reg[load_row]   <= s_next_on_a   & STATE_MASK;
            table_b_reg[load_row]   <= s_next_on_b   & STATE_MASK;
            table_eps_reg[load_row] <= s_next_on_eps & STATE_MASK;
        end
    end

    // configuration port, decoded on the word address
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_AW-1:2] == ADDR_ACCEPT_MASK[APB_AW-1:2]);
    assign prdata  = cfg_sel ? APB_DW'(accept_mask_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_mask_reg <= '0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            accept_mask_reg <= pwdata[FIELD_W-1:0];
        end
    end

    // sequencer: symbol scan, closure passes, result hand-off
    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        work_next       = work_reg;
        changed_next    = changed_reg;
        symbol_next     = symbol_reg;
        active_next     = active_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_active_next   = m_active_reg;
        m_accepted_next = m_accepted_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    row_next     = '0;
                    changed_next = 1'b0;
                    symbol_next  = s_symbol_is_b;
                    case (s_operation)
                        OP_START: begin
                            work_next  = FIELD_W'(1) & STATE_MASK;
                            state_next = ST_CLOSE;
                        end
                        OP_FEED: begin
                            work_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            work_next  = active_reg;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // union of successors of the active states
                if (active_reg[row_reg]) begin
                    work_next = work_reg | sym_row;
                end
                if (row_reg == LAST_ROW) begin
                    row_next   = '0;
                    state_next = ST_CLOSE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_CLOSE: begin
                // in-place closure pass, repeated until nothing is added
                work_next    = closed;
                changed_next = changed_reg || (closed != work_reg);
                if (row_reg == LAST_ROW) begin
                    row_next     = '0;
                    changed_next = 1'b0;
                    if (!(changed_reg || (closed != work_reg))) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    active_next     = work_reg;
                    m_valid_next    = 1'b1;
                    m_active_next   = work_reg;
                    m_accepted_next = |(work_reg & accept_mask_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        row_reg        <= row_next;
        work_reg       <= work_next;
        changed_reg    <= changed_next;
        symbol_reg     <= symbol_next;
        m_active_reg   <= m_active_next;
        m_accepted_reg <= m_accepted_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_active_states = m_active_reg;
    assign m_accepted      = m_accepted_reg;

    // a closure pass only ever adds states
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE && $past(state_reg == ST_CLOSE))
            |-> ((work_reg & $past(work_reg)) == $past(work_reg)))
        else $error("closure pass dropped an active state");

    // the active set only moves when a result is handed off
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(active_reg) |-> $past(state_reg == ST_DONE))
        else $error("active set changed outside result hand-off");

    // a row load goes straight to its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == OP_LOAD) |=> (state_reg == ST_DONE))
        else $error("row load did not go to result stage");

    // a pending result is only dropped when taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid_reg) |-> $past(m_ready))
        else $error("result word dropped without m_ready");

    // the working set never holds states beyond the automaton
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ((work_reg & ~STATE_MASK) == '0))
        else $error("working set holds an out-of-range state");

endmodule
